### hdl/polygon_unit_normal_core_assert.svh
// Assertion macros for the polygon normal RTL.
`ifndef POLYGON_UNIT_NORMAL_CORE_ASSERT_SVH
`define POLYGON_UNIT_NORMAL_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PUN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PUN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pun_pkg.sv
// Package with constants and types of the polygon unit normal block.
package pun_pkg;

  localparam int unsigned COORD_BITS_DEF   = 16;
  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned NORM_BITS        = 24;
  localparam int unsigned FRAC_SHIFT       = 20;
  localparam int unsigned SQRT_PRE         = 12;
  localparam int unsigned L2_W             = 50;
  localparam int unsigned SQ_W             = 64;
  localparam int unsigned LEN_W            = 32;
  localparam int unsigned REM_W            = 48;
  localparam int unsigned QUO_W            = 16;
  localparam int unsigned NRM_W            = 16;
  localparam int unsigned CNT_OUT_W        = 11;
  localparam logic [QUO_W-1:0] Q_ONE       = 16'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CROSS,
    ST_ABS,
    ST_MAX,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIVSET,
    ST_DIV,
    ST_DONE
  } pun_state_e;

endpackage

### hdl/pun_mul.sv
// Shared signed multiplier with a registered product.
module pun_mul #(
  parameter int unsigned W = 25
) (
  input  logic                  clk_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  logic signed [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### hdl/polygon_unit_normal_core.sv
// Top level of the polygon unit normal block (Newell's method).
//
// Vertices come in on the slave stream, one per transfer, x/y/z packed in
// tdata from the lowest bit up, tlast on the final vertex of a polygon.
// One result per polygon leaves on the master stream after the final vertex.
// Every product goes through one shared registered multiplier under a small
// sequencer, so the block is busy while an item is worked on.
// Sequence: the first vertex of a polygon is only stored, unless it is also
// the final one; every later vertex takes the six multiplies of one cross
// product with the previous vertex. A final vertex adds the closing cross
// product with the first vertex, then magnitudes and maximum, shifts that
// normalize the maximum to NORM_BITS (24) bits, the squared length, a
// bit-serial square root and one restoring division per component before
// tvalid rises.
// The result sits in an output register; the block takes new vertices while
// it waits and only stalls when the next result is ready and the old one has
// not been taken. Reset clears the first and previous vertices, sums, count and tvalid.
module polygon_unit_normal_core #(
  parameter int unsigned COORD_BITS   = pun_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_VERTICES = pun_pkg::MAX_VERTICES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: vertex_x, vertex_y, vertex_z (COORD_BITS each), zero fill.
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  input  logic                                 s_axis_tlast_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tdata: normal_x, normal_y, normal_z (16 each), vertex_count (11), zero fill.
  output logic [63:0]                          m_axis_tdata_o,
  // tuser: degenerate.
  output logic                                 m_axis_tuser_o
);

  `include "polygon_unit_normal_core_assert.svh"

  localparam int unsigned NB    = pun_pkg::NORM_BITS;
  localparam int unsigned SUM_W = 2*COORD_BITS + 11;
  localparam int unsigned MUL_W = (COORD_BITS > NB) ? COORD_BITS : NB + 1;
  localparam int unsigned PROD_W = 2*MUL_W;
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned L2_W  = pun_pkg::L2_W;
  localparam int unsigned SQ_W  = pun_pkg::SQ_W;
  localparam int unsigned LEN_W = pun_pkg::LEN_W;
  localparam int unsigned REM_W = pun_pkg::REM_W;
  localparam int unsigned QUO_W = pun_pkg::QUO_W;
  localparam int unsigned NRM_W = pun_pkg::NRM_W;
  localparam int unsigned CO_W  = pun_pkg::CNT_OUT_W;

  pun_pkg::pun_state_e state_q, state_d;

  logic signed [COORD_BITS-1:0] vin   [3];
  logic signed [COORD_BITS-1:0] first_q [3];
  logic signed [COORD_BITS-1:0] prev_q  [3];
  logic signed [COORD_BITS-1:0] cur_q   [3];
  logic signed [COORD_BITS-1:0] ca_q    [3];
  logic signed [COORD_BITS-1:0] cb_q    [3];
  logic [SUM_W-1:0]             sum_q   [3];
  logic [SUM_W-1:0]             mag_q   [3];
  logic [2:0]                   neg_q;
  logic [SUM_W-1:0]             mmax_q;
  logic [CNT_W-1:0]             count_q;
  logic                         last_q;
  logic                         close_q;
  logic [2:0]                   step_q;
  logic [L2_W-1:0]              l2_q;
  logic [L2_W-1:0]              l2_next;
  logic [SQ_W-1:0]              val_q;
  logic [SQ_W-1:0]              res_q;
  logic [SQ_W-1:0]              bit_q;
  logic [SQ_W-1:0]              sq_try;
  logic [REM_W-1:0]             rem_q;
  logic [REM_W-1:0]             dv_q;
  logic [QUO_W-1:0]             quo_q;
  logic [QUO_W-1:0]             quo_fin;
  logic [QUO_W-1:0]             quo_sat;
  logic                         div_ge;
  logic [3:0]                   dstep_q;
  logic [1:0]                   comp_q;
  logic [NRM_W-1:0]             nrm_q   [3];
  logic                         deg_q;
  logic                         out_valid_q;
  logic [NRM_W-1:0]             onx_q, ony_q, onz_q;
  logic                         odeg_q;
  logic [CO_W-1:0]              ocnt_q;
  logic                         in_acc;
  logic                         out_load;
  logic signed [MUL_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]     prod;
  logic [1:0]                   acc_idx;
  logic                         acc_sub;
  logic [SUM_W-1:0]             prod_ext;
  logic [LEN_W-1:0]             len;
  logic                         mm_hi, mm_lo;

  for (genvar k = 0; k < 3; k++) begin : g_in
    assign vin[k] = $signed(s_axis_tdata_i[k*COORD_BITS +: COORD_BITS]);
  end

  assign s_axis_tready_o = (state_q == pun_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == pun_pkg::ST_DONE) &&
                           (!out_valid_q || m_axis_tready_i);

  assign mm_hi   = (mmax_q[SUM_W-1:NB] != '0);
  assign mm_lo   = !mmax_q[NB-1];
  assign len     = res_q[LEN_W-1:0];
  assign acc_idx = 2'((step_q - 3'd1) >> 1);
  assign acc_sub = step_q[0] == 1'b0;
  assign prod_ext = SUM_W'(prod);
  assign l2_next = l2_q + L2_W'(unsigned'(prod));
  assign sq_try  = res_q + bit_q;
  assign div_ge  = (rem_q >= dv_q);
  assign quo_fin = {quo_q[QUO_W-2:0], div_ge};
  assign quo_sat = (quo_fin > pun_pkg::Q_ONE) ? pun_pkg::Q_ONE : quo_fin;

  pun_mul #(.W(MUL_W)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pun_pkg::ST_IDLE: begin
        if (in_acc && ((count_q != '0) || s_axis_tlast_i)) state_d = pun_pkg::ST_CROSS;
      end
      pun_pkg::ST_CROSS: begin
        if (step_q == 3'd6 && !close_q) begin
          state_d = last_q ? pun_pkg::ST_ABS : pun_pkg::ST_IDLE;
        end
      end
      pun_pkg::ST_ABS:   state_d = pun_pkg::ST_MAX;
      pun_pkg::ST_MAX:   state_d = pun_pkg::ST_SHIFT;
      pun_pkg::ST_SHIFT: begin
        // The maximum is valid from here on; a zero sum skips normalization.
        if (mmax_q == '0) state_d = pun_pkg::ST_DONE;
        else if (!mm_hi && !mm_lo) state_d = pun_pkg::ST_SQ;
      end
      pun_pkg::ST_SQ: begin
        if (step_q == 3'd3) state_d = pun_pkg::ST_SQRT;
      end
      pun_pkg::ST_SQRT: begin
        if (bit_q[0]) state_d = pun_pkg::ST_DIVSET;
      end
      pun_pkg::ST_DIVSET: state_d = pun_pkg::ST_DIV;
      pun_pkg::ST_DIV: begin
        if (dstep_q == 4'd15) begin
          state_d = (comp_q == 2'd2) ? pun_pkg::ST_DONE : pun_pkg::ST_DIVSET;
        end
      end
      pun_pkg::ST_DONE: begin
        if (out_load) state_d = pun_pkg::ST_IDLE;
      end
      default: state_d = pun_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operands: cross product terms, then the squared magnitudes.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      pun_pkg::ST_CROSS: begin
        case (step_q)
          3'd0: begin mul_a = MUL_W'(ca_q[1]); mul_b = MUL_W'(cb_q[2]); end
          3'd1: begin mul_a = MUL_W'(ca_q[2]); mul_b = MUL_W'(cb_q[1]); end
          3'd2: begin mul_a = MUL_W'(ca_q[2]); mul_b = MUL_W'(cb_q[0]); end
          3'd3: begin mul_a = MUL_W'(ca_q[0]); mul_b = MUL_W'(cb_q[2]); end
          3'd4: begin mul_a = MUL_W'(ca_q[0]); mul_b = MUL_W'(cb_q[1]); end
          3'd5: begin mul_a = MUL_W'(ca_q[1]); mul_b = MUL_W'(cb_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      pun_pkg::ST_SQ: begin
        if (step_q < 3'd3) begin
          mul_a = MUL_W'($signed({1'b0, mag_q[step_q[1:0]][NB-1:0]}));
          mul_b = mul_a;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pun_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      close_q     <= 1'b0;
      last_q      <= 1'b0;
      dstep_q     <= '0;
      comp_q      <= '0;
      for (int k = 0; k < 3; k++) begin
        first_q[k] <= '0;
        prev_q[k]  <= '0;
        sum_q[k]   <= '0;
      end
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid_o && m_axis_tready_i && !out_load) out_valid_q <= 1'b0;
      case (state_q)
        pun_pkg::ST_IDLE: begin
          if (in_acc) begin
            last_q  <= s_axis_tlast_i;
            step_q  <= '0;
            if (count_q < CNT_W'(MAX_VERTICES)) count_q <= count_q + 1'b1;
            for (int k = 0; k < 3; k++) begin
              cur_q[k]  <= vin[k];
              prev_q[k] <= vin[k];
              if (count_q == '0) first_q[k] <= vin[k];
              ca_q[k] <= (count_q != '0) ? prev_q[k] : vin[k];
              cb_q[k] <= vin[k];
            end
            close_q <= (count_q != '0) && s_axis_tlast_i;
          end
        end
        pun_pkg::ST_CROSS: begin
          if (step_q != 3'd0) begin
            sum_q[acc_idx] <= acc_sub ? sum_q[acc_idx] - prod_ext
                                      : sum_q[acc_idx] + prod_ext;
          end
          if (step_q == 3'd6) begin
            step_q <= '0;
            if (close_q) begin
              // Closing term: last vertex cross first vertex.
              close_q <= 1'b0;
              for (int k = 0; k < 3; k++) begin
                ca_q[k] <= cur_q[k];
                cb_q[k] <= first_q[k];
              end
            end
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        pun_pkg::ST_ABS: begin
          deg_q <= 1'b0;
          for (int k = 0; k < 3; k++) begin
            neg_q[k] <= sum_q[k][SUM_W-1];
            mag_q[k] <= sum_q[k][SUM_W-1] ? (~sum_q[k] + 1'b1) : sum_q[k];
            nrm_q[k] <= '0;
          end
        end
        pun_pkg::ST_MAX: begin
          mmax_q <= (mag_q[0] > mag_q[1]) ?
                    ((mag_q[0] > mag_q[2]) ? mag_q[0] : mag_q[2]) :
                    ((mag_q[1] > mag_q[2]) ? mag_q[1] : mag_q[2]);
          step_q <= '0;
        end
        pun_pkg::ST_SHIFT: begin
          if (mmax_q == '0) begin
            deg_q <= 1'b1;
          end else if (mm_hi) begin
            mmax_q <= mmax_q >> 1;
            for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
          end else if (mm_lo) begin
            mmax_q <= mmax_q << 1;
            for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
          end
          l2_q <= '0;
        end
        pun_pkg::ST_SQ: begin
          if (step_q != 3'd0) l2_q <= l2_next;
          step_q <= step_q + 3'd1;
          if (step_q == 3'd3) begin
            val_q  <= SQ_W'(l2_next) << pun_pkg::SQRT_PRE;
            res_q  <= '0;
            bit_q  <= SQ_W'(1) << (SQ_W - 2);
            comp_q <= '0;
          end
        end
        pun_pkg::ST_SQRT: begin
          if (val_q >= sq_try) begin
            val_q <= val_q - sq_try;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        pun_pkg::ST_DIVSET: begin
          rem_q   <= (REM_W'(mag_q[comp_q][NB-1:0]) << pun_pkg::FRAC_SHIFT) +
                     REM_W'(len >> 1);
          dv_q    <= REM_W'(len) << (QUO_W - 1);
          quo_q   <= '0;
          dstep_q <= '0;
        end
        pun_pkg::ST_DIV: begin
          if (div_ge) rem_q <= rem_q - dv_q;
          dv_q    <= dv_q >> 1;
          quo_q   <= quo_fin;
          dstep_q <= dstep_q + 4'd1;
          if (dstep_q == 4'd15) begin
            nrm_q[comp_q] <= neg_q[comp_q] ? (~quo_sat + 1'b1) : quo_sat;
            comp_q <= comp_q + 2'd1;
          end
        end
        pun_pkg::ST_DONE: begin
          if (mmax_q == '0) begin
            deg_q <= 1'b1;
          end
          if (out_load) begin
            out_valid_q <= 1'b1;
            onx_q  <= nrm_q[0];
            ony_q  <= nrm_q[1];
            onz_q  <= nrm_q[2];
            odeg_q <= (mmax_q == '0);
            ocnt_q <= CO_W'(count_q);
            count_q <= '0;
            for (int k = 0; k < 3; k++) begin
              first_q[k] <= '0;
              prev_q[k]  <= '0;
              sum_q[k]   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, ocnt_q, onz_q, ony_q, onx_q};
  assign m_axis_tuser_o  = odeg_q;

  `PUN_ASSERT_IMP(a_deg_zero, m_axis_tvalid_o && m_axis_tuser_o,
    onx_q == '0 && ony_q == '0 && onz_q == '0, "degenerate result with nonzero normal")
  `PUN_ASSERT_IMP(a_count_max, 1'b1, count_q <= CNT_W'(MAX_VERTICES),
    "vertex count above maximum")
  `PUN_ASSERT_IMP(a_norm_range, state_q == pun_pkg::ST_SQ,
    !mm_hi && !mm_lo, "normalized maximum outside its range")
  `PUN_ASSERT_NXT(a_load_valid, out_load, out_valid_q,
    "result load did not raise tvalid")
  `PUN_ASSERT_IMP(a_deg_flag, state_q == pun_pkg::ST_DONE && mmax_q != '0,
    !deg_q, "degenerate flag set for nonzero sum")

endmodule
